@@ sv/dts_pkg.sv @@
// dts_pkg: shared types, codes and helpers for the deadline task scheduler.
// No dependencies; imported by dts_ctrl, dts_datapath and the top level.

package dts_pkg;

   localparam logic [1:0] CMD_SCHEDULE   = 2'd0;
   localparam logic [1:0] CMD_RESCHEDULE = 2'd1;
   localparam logic [1:0] CMD_UNSCHEDULE = 2'd2;
   localparam logic [1:0] CMD_FIRE       = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // table pass modes
   localparam logic [2:0] MODE_SCAN   = 3'd0;  // earliest over all entries
   localparam logic [2:0] MODE_UPDATE = 3'd1;  // rewrite matching ids, earliest after
   localparam logic [2:0] MODE_PURGE  = 3'd2;  // drop matching ids, compact
   localparam logic [2:0] MODE_COUNT  = 3'd3;  // count due entries, earliest of the rest
   localparam logic [2:0] MODE_EMIT   = 3'd4;  // drop due entries, emit them

   localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;
   localparam logic [31:0] WRAP_OFFSET = 32'h7FFF_FFFF;

   localparam int MAX_RESULTS = 32;
   localparam int KILL_W      = 6;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  task_id;
      logic [31:0] deadline;
      logic [31:0] now_tick;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  fired_task;
      logic        fired_valid;
      logic [31:0] next_deadline;
      logic        deadline_valid;
      logic        compare_reload;
      logic [1:0]  status;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic       load;
      logic       pass_start;
      logic [2:0] mode;
      logic       finish;
   } ctrl_type;

   typedef struct packed {
      logic pass_done;
      logic table_empty;
   } stat_type;

   function automatic logic [31:0] order_key(input logic [31:0] dl, input logic wrap);
      return wrap ? dl + WRAP_OFFSET : dl;
   endfunction

endpackage

@@ sv/dts_ram.sv @@
// dts_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module dts_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/dts_ctrl.sv @@
// dts_ctrl: command sequencer of the deadline task scheduler.
// Depends on dts_pkg; drives dts_datapath through ctrl_type, reads stat_type.

module dts_ctrl import dts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] command,
   input  stat_type   stat,
   output ctrl_type   ctrl,
   output logic       busy
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PASS  = 2'd1;
   localparam logic [1:0] S_FINAL = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [2:0] mode_ff, mode_in;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      mode_in  = mode_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.load       = 1'b1;
               ctrl.pass_start = 1'b1;
               cmd_in          = command;
               unique case (command)
                  CMD_RESCHEDULE: mode_in = MODE_UPDATE;
                  CMD_UNSCHEDULE: mode_in = MODE_PURGE;
                  default:        mode_in = MODE_SCAN;
               endcase
               ctrl.mode = mode_in;
               state_in  = S_PASS;
            end
         end
         S_PASS: begin
            if (stat.pass_done) begin
               if (cmd_ff == CMD_FIRE) begin
                  if (mode_ff == MODE_SCAN) begin
                     if (stat.table_empty) begin
                        state_in = S_FINAL;
                     end else begin
                        mode_in         = MODE_COUNT;
                        ctrl.pass_start = 1'b1;
                        ctrl.mode       = MODE_COUNT;
                     end
                  end else if (mode_ff == MODE_COUNT) begin
                     mode_in         = MODE_EMIT;
                     ctrl.pass_start = 1'b1;
                     ctrl.mode       = MODE_EMIT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            ctrl.finish = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      mode_ff <= mode_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ sv/dts_datapath.sv @@
// dts_datapath: task table RAM, scan pipeline, earliest trackers and result register.
// Depends on dts_pkg and dts_ram; commanded by dts_ctrl.

module dts_datapath import dts_pkg::*; #(
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_BITS     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_type     ctrl,
   input  req_word_type req_word,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = ID_BITS + 32;

   logic [2:0]         mode_ff, mode_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [31:0]        dl_ff, dl_in;
   logic               wrap_ff, wrap_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic               active_ff, active_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]   pipe_idx_ff, pipe_idx_in;
   logic               found_ff, found_in;
   logic               pre_vld_ff, pre_vld_in;
   logic [31:0]        pre_key_ff, pre_key_in;
   logic [31:0]        pre_dl_ff, pre_dl_in;
   logic [ID_BITS-1:0] pre_id_ff, pre_id_in;
   logic               post_vld_ff, post_vld_in;
   logic [31:0]        post_key_ff, post_key_in;
   logic [31:0]        post_dl_ff, post_dl_in;
   logic [KILL_W-1:0]  kill_cnt_ff, kill_cnt_in;
   logic [KILL_W-1:0]  total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   logic [ID_BITS+7:0] req_id_wide, e_id_wide;
   logic [ID_BITS-1:0] req_id, e_id;
   logic [31:0]        e_dl, cand_dl, cand_key, new_key;
   logic               issue_done, pass_done, match_id, kill, cap_ok, full, new_wins;
   logic               emit_last;

   dts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_id_wide = {{ID_BITS{1'b0}}, req_word.task_id};
   assign req_id      = req_id_wide[ID_BITS-1:0];
   assign e_id        = rd_data[ENTRY_W-1:32];
   assign e_dl        = rd_data[31:0];
   assign e_id_wide   = {8'b0, e_id};

   assign issue_done = (rd_ptr_ff >= count_ff);
   assign pass_done  = active_ff && issue_done && !pipe_vld_ff;
   assign match_id   = (e_id == id_ff);
   assign cand_dl    = (mode_ff == MODE_UPDATE && match_id) ? dl_ff : e_dl;
   assign cand_key   = order_key(cand_dl, wrap_ff);
   assign cap_ok     = (kill_cnt_ff < KILL_W'(MAX_RESULTS));
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign new_key    = order_key(dl_ff, wrap_ff);
   assign new_wins   = !pre_vld_ff || (new_key < pre_key_ff);
   assign emit_last  = (KILL_W'(kill_cnt_ff + KILL_W'(1)) == total_ff);
   assign rd_addr    = rd_ptr_ff[IDX_W-1:0];

   always_comb begin
      unique case (mode_ff) inside
         MODE_PURGE:             kill = match_id;
         MODE_COUNT, MODE_EMIT:  kill = (e_dl == pre_dl_ff) && cap_ok;
         default:                kill = 1'b0;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      dl_in        = dl_ff;
      wrap_in      = wrap_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      active_in    = active_ff;
      pipe_vld_in  = 1'b0;
      pipe_idx_in  = pipe_idx_ff;
      found_in     = found_ff;
      pre_vld_in   = pre_vld_ff;
      pre_key_in   = pre_key_ff;
      pre_dl_in    = pre_dl_ff;
      pre_id_in    = pre_id_ff;
      post_vld_in  = post_vld_ff;
      post_key_in  = post_key_ff;
      post_dl_in   = post_dl_ff;
      kill_cnt_in  = kill_cnt_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;

      if (ctrl.load) begin
         cmd_in  = req_word.command;
         id_in   = req_id;
         dl_in   = req_word.deadline;
         wrap_in = (req_word.now_tick > HALF_RANGE);
      end

      // read issue
      if (active_ff && !issue_done) begin
         rd_en       = 1'b1;
         rd_ptr_in   = CNT_W'(rd_ptr_ff + CNT_W'(1));
         pipe_vld_in = 1'b1;
         pipe_idx_in = rd_ptr_ff[IDX_W-1:0];
      end

      // entry stage
      if (pipe_vld_ff) begin
         if (mode_ff == MODE_SCAN || mode_ff == MODE_UPDATE || mode_ff == MODE_PURGE) begin
            if (!pre_vld_ff || cand_key < pre_key_ff) begin
               pre_vld_in = 1'b1;
               pre_key_in = cand_key;
               pre_dl_in  = cand_dl;
               pre_id_in  = e_id;
            end
         end
         if ((mode_ff == MODE_UPDATE || mode_ff == MODE_PURGE) && match_id) begin
            found_in = 1'b1;
         end
         if (mode_ff == MODE_UPDATE && match_id) begin
            wr_en   = 1'b1;
            wr_addr = pipe_idx_ff;
            wr_data = {e_id, dl_ff};
         end
         if ((mode_ff == MODE_PURGE || mode_ff == MODE_COUNT) && !kill) begin
            if (!post_vld_ff || cand_key < post_key_ff) begin
               post_vld_in = 1'b1;
               post_key_in = cand_key;
               post_dl_in  = cand_dl;
            end
         end
         if ((mode_ff == MODE_COUNT || mode_ff == MODE_EMIT) && kill) begin
            kill_cnt_in = KILL_W'(kill_cnt_ff + KILL_W'(1));
         end
         if ((mode_ff == MODE_PURGE || mode_ff == MODE_EMIT) && !kill) begin
            wr_en     = 1'b1;
            wr_addr   = wr_ptr_ff[IDX_W-1:0];
            wr_data   = {e_id, e_dl};
            wr_ptr_in = CNT_W'(wr_ptr_ff + CNT_W'(1));
         end
         if (mode_ff == MODE_EMIT && kill) begin
            rsp_valid_in          = 1'b1;
            rsp_in                = '0;
            rsp_in.fired_task     = e_id_wide[7:0];
            rsp_in.fired_valid    = 1'b1;
            rsp_in.next_deadline  = post_vld_ff ? post_dl_ff : 32'd0;
            rsp_in.deadline_valid = post_vld_ff;
            rsp_in.compare_reload = post_vld_ff;
            rsp_in.status         = STATUS_OK;
            rsp_in.last           = emit_last;
         end
      end

      if (pass_done) begin
         active_in = 1'b0;
         if (mode_ff == MODE_PURGE || mode_ff == MODE_EMIT) begin
            count_in = wr_ptr_ff;
         end
      end

      if (ctrl.pass_start) begin
         active_in = 1'b1;
         mode_in   = ctrl.mode;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         unique case (ctrl.mode)
            MODE_SCAN: begin
               pre_vld_in = 1'b0;
            end
            MODE_UPDATE: begin
               pre_vld_in = 1'b0;
               found_in   = 1'b0;
            end
            MODE_PURGE: begin
               pre_vld_in  = 1'b0;
               post_vld_in = 1'b0;
               found_in    = 1'b0;
            end
            MODE_COUNT: begin
               post_vld_in = 1'b0;
               kill_cnt_in = '0;
            end
            MODE_EMIT: begin
               total_in    = kill_cnt_ff;
               kill_cnt_in = '0;
            end
            default: begin
               active_in = 1'b0;
            end
         endcase
      end

      if (ctrl.finish) begin
         rsp_valid_in          = 1'b1;
         rsp_in                = '0;
         rsp_in.last           = 1'b1;
         rsp_in.status         = STATUS_OK;
         rsp_in.deadline_valid = pre_vld_ff;
         rsp_in.next_deadline  = pre_vld_ff ? pre_dl_ff : 32'd0;
         unique case (cmd_ff) inside
            CMD_SCHEDULE, CMD_RESCHEDULE: begin
               if (cmd_ff == CMD_RESCHEDULE && found_ff) begin
                  rsp_in.compare_reload = pre_vld_ff && (pre_id_ff == id_ff);
               end else if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  wr_en                 = 1'b1;
                  wr_addr               = count_ff[IDX_W-1:0];
                  wr_data               = {id_ff, dl_ff};
                  count_in              = CNT_W'(count_ff + CNT_W'(1));
                  rsp_in.deadline_valid = 1'b1;
                  rsp_in.next_deadline  = new_wins ? dl_ff : pre_dl_ff;
                  rsp_in.compare_reload = new_wins;
               end
            end
            CMD_UNSCHEDULE: begin
               if (!found_ff) begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end else begin
                  rsp_in.deadline_valid = post_vld_ff;
                  rsp_in.next_deadline  = post_vld_ff ? post_dl_ff : 32'd0;
                  rsp_in.compare_reload = post_vld_ff && pre_vld_ff && (pre_id_ff == id_ff);
               end
            end
            CMD_FIRE: begin
               rsp_in.deadline_valid = 1'b0;
               rsp_in.next_deadline  = 32'd0;
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pipe_vld_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pipe_vld_ff  <= pipe_vld_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      dl_ff       <= dl_in;
      wrap_ff     <= wrap_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      pipe_idx_ff <= pipe_idx_in;
      found_ff    <= found_in;
      pre_vld_ff  <= pre_vld_in;
      pre_key_ff  <= pre_key_in;
      pre_dl_ff   <= pre_dl_in;
      pre_id_ff   <= pre_id_in;
      post_vld_ff <= post_vld_in;
      post_key_ff <= post_key_in;
      post_dl_ff  <= post_dl_in;
      kill_cnt_ff <= kill_cnt_in;
      total_ff    <= total_in;
      rsp_ff      <= rsp_in;
   end

   assign stat.pass_done   = pass_done;
   assign stat.table_empty = !pre_vld_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word         = rsp_ff;

endmodule

@@ sv/deadline_task_scheduler.sv @@
// deadline_task_scheduler: top level of the deadline task scheduler.
// Depends on dts_pkg, dts_ctrl, dts_datapath (and dts_ram below it).
//
// Usage: a command word is taken on req_word at a clock edge with start high
// and busy low. Commands are schedule, reschedule, unschedule and fire.
// Results come out on rsp_word, each for one cycle with rsp_valid high; the
// receiver has no way to stall them. The final result of a command has last set.
// Each pass over the task RAM reads one entry a cycle. Schedule, reschedule
// and unschedule give their single result after one pass, at the same edge
// at which busy clears. Fire on a non-empty table needs three passes
// (earliest, count of due entries, remove and emit): one result per fired
// task, in age order, given as the third pass reads the entries; busy
// clears when that pass ends. On an empty table fire answers after one
// pass and clears busy at the same edge as its result appears.
// After a single-result command the next one may be accepted while its
// result is on the ports.
// Reset empties the table; the RAM contents are left as they are.

module deadline_task_scheduler import dts_pkg::*; #(
   parameter int QUEUE_DEPTH = 32,
   parameter int ID_BITS     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   ctrl_type ctrl;
   stat_type stat;

   dts_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_word.command),
      .stat    (stat),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   dts_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_word  (req_word),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
